### sv/table_driven_token_scanner_core_defines.svh
// Assertion helpers for the token scanner. Both sample on the rising edge of
// i_clk and stay quiet while i_rst_n is low.
`ifndef TABLE_DRIVEN_TOKEN_SCANNER_CORE_DEFINES_SVH
`define TABLE_DRIVEN_TOKEN_SCANNER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tdts_pkg.sv
`timescale 1ns / 1ps

package tdts_pkg;

    // Default saturation point of the lexeme length counter.
    localparam int LEXEME_MAX_DEF = 63;

    // Only the first bytes of a lexeme are kept, enough for the longest keyword.
    localparam int PREFIX_BYTES = 6;

    // Result queue: a power of two deep, written with up to two words a cycle.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

    // Input word: one source byte or the end-of-source mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } t_in_word;

    // Output word: one token.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] line_number;
        logic [15:0] column;
        logic [5:0]  lexeme_length;
        logic        last;
    } t_out_word;

    // Tokens produced by one input word, in order; num is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] num;
        t_out_word  word0;
        t_out_word  word1;
    } t_push;

    // Result queue status seen by the input side.
    typedef struct packed {
        logic                 room;
        logic [OUT_LVL_W-1:0] level;
    } t_fifo_stat;

    // Token kinds.
    localparam logic [4:0] KIND_ELSE   = 5'd0;
    localparam logic [4:0] KIND_IF     = 5'd1;
    localparam logic [4:0] KIND_INT    = 5'd2;
    localparam logic [4:0] KIND_RETURN = 5'd3;
    localparam logic [4:0] KIND_VOID   = 5'd4;
    localparam logic [4:0] KIND_WHILE  = 5'd5;
    localparam logic [4:0] KIND_ID     = 5'd6;
    localparam logic [4:0] KIND_NUM    = 5'd7;
    localparam logic [4:0] KIND_GT     = 5'd8;
    localparam logic [4:0] KIND_ERROR  = 5'd28;
    localparam logic [4:0] KIND_END    = 5'd29;

    // Character classes.
    localparam logic [4:0] CLS_LETTER = 5'd0;
    localparam logic [4:0] CLS_DIGIT  = 5'd1;
    localparam logic [4:0] CLS_PLUS   = 5'd2;
    localparam logic [4:0] CLS_MINUS  = 5'd3;
    localparam logic [4:0] CLS_STAR   = 5'd4;
    localparam logic [4:0] CLS_SEMI   = 5'd5;
    localparam logic [4:0] CLS_COMMA  = 5'd6;
    localparam logic [4:0] CLS_LPAREN = 5'd7;
    localparam logic [4:0] CLS_RPAREN = 5'd8;
    localparam logic [4:0] CLS_LBRACK = 5'd9;
    localparam logic [4:0] CLS_RBRACK = 5'd10;
    localparam logic [4:0] CLS_LBRACE = 5'd11;
    localparam logic [4:0] CLS_RBRACE = 5'd12;
    localparam logic [4:0] CLS_GT     = 5'd13;
    localparam logic [4:0] CLS_LT     = 5'd14;
    localparam logic [4:0] CLS_EQ     = 5'd15;
    localparam logic [4:0] CLS_BANG   = 5'd16;
    localparam logic [4:0] CLS_SLASH  = 5'd17;
    localparam logic [4:0] CLS_SPACE  = 5'd18;
    localparam logic [4:0] CLS_OTHER  = 5'd19;

    // Scanning states (held) and accepting states (only ever a target).
    localparam logic [4:0] ST_START         = 5'd0;
    localparam logic [4:0] ST_ID            = 5'd1;
    localparam logic [4:0] ST_NUM           = 5'd2;
    localparam logic [4:0] ST_GT            = 5'd3;
    localparam logic [4:0] ST_LT            = 5'd4;
    localparam logic [4:0] ST_ASSIGN        = 5'd5;
    localparam logic [4:0] ST_BANG          = 5'd6;
    localparam logic [4:0] ST_SLASH         = 5'd7;
    localparam logic [4:0] ST_COMMENT       = 5'd8;
    localparam logic [4:0] ST_COMMENT_STAR  = 5'd9;
    localparam logic [4:0] ST_ACC_ID        = 5'd10;
    localparam logic [4:0] ST_ACC_NUM       = 5'd11;
    localparam logic [4:0] ST_ACC_GT        = 5'd12;
    localparam logic [4:0] ST_ACC_GE        = 5'd13;
    localparam logic [4:0] ST_ACC_LT        = 5'd14;
    localparam logic [4:0] ST_ACC_LE        = 5'd15;
    localparam logic [4:0] ST_ACC_ASSIGN    = 5'd16;
    localparam logic [4:0] ST_ACC_EQ        = 5'd17;
    localparam logic [4:0] ST_ACC_NE        = 5'd18;
    localparam logic [4:0] ST_ACC_COMMENT   = 5'd19;
    localparam logic [4:0] ST_ACC_PLUS      = 5'd20;
    localparam logic [4:0] ST_ACC_DIV       = 5'd31;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Keywords, first byte in the low bits, with their lengths and kinds.
    localparam int KW_COUNT = 6;
    localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_656C_7365 & 48'h0 | 48'h0000_6573_6C65,  // else
        48'h0000_0000_6669,                                // if
        48'h0000_0074_6E69,                                // int
        48'h6E72_7574_6572,                                // return
        48'h0000_6469_6F76,                                // void
        48'h0065_6C69_6877                                 // while
    };
    localparam int KW_LEN [KW_COUNT] = '{4, 2, 3, 6, 4, 5};
    localparam logic [4:0] KW_KIND [KW_COUNT] = '{
        KIND_ELSE, KIND_IF, KIND_INT, KIND_RETURN, KIND_VOID, KIND_WHILE
    };

    // One entry of the transition table.
    typedef struct packed {
        logic       err;
        logic       adv;
        logic [4:0] ns;
    } t_move;

    // Sort a byte into its character class.
    function automatic logic [4:0] char_class(input logic [7:0] c);
        logic [4:0] k;
        k = CLS_OTHER;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            k = CLS_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = CLS_DIGIT;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            k = CLS_SPACE;
        end else begin
            case (c)
                8'h2B: k = CLS_PLUS;
                8'h2D: k = CLS_MINUS;
                8'h2A: k = CLS_STAR;
                8'h3B: k = CLS_SEMI;
                8'h2C: k = CLS_COMMA;
                8'h28: k = CLS_LPAREN;
                8'h29: k = CLS_RPAREN;
                8'h5B: k = CLS_LBRACK;
                8'h5D: k = CLS_RBRACK;
                8'h7B: k = CLS_LBRACE;
                8'h7D: k = CLS_RBRACE;
                8'h3E: k = CLS_GT;
                8'h3C: k = CLS_LT;
                8'h3D: k = CLS_EQ;
                8'h21: k = CLS_BANG;
                8'h2F: k = CLS_SLASH;
                default: k = CLS_OTHER;
            endcase
        end
        return k;
    endfunction

    // Transition table: next state, whether the byte is consumed, lexical error.
    function automatic t_move next_move(input logic [4:0] st, input logic [4:0] cls);
        t_move m;
        m.err = 1'b0;
        m.adv = 1'b1;
        m.ns  = ST_START;
        case (st)
            ST_ID: begin
                m.adv = (cls == CLS_LETTER);
                m.err = (cls == CLS_DIGIT) || (cls == CLS_OTHER);
                m.ns  = (cls == CLS_LETTER) ? ST_ID : ST_ACC_ID;
            end
            ST_NUM: begin
                m.adv = (cls == CLS_DIGIT);
                m.err = (cls == CLS_LETTER) || (cls == CLS_OTHER);
                m.ns  = (cls == CLS_DIGIT) ? ST_NUM : ST_ACC_NUM;
            end
            ST_GT: begin
                m.adv = (cls == CLS_EQ);
                m.err = (cls == CLS_OTHER);
                m.ns  = (cls == CLS_EQ) ? ST_ACC_GE : ST_ACC_GT;
            end
            ST_LT: begin
                m.adv = (cls == CLS_EQ);
                m.err = (cls == CLS_OTHER);
                m.ns  = (cls == CLS_EQ) ? ST_ACC_LE : ST_ACC_LT;
            end
            ST_ASSIGN: begin
                m.adv = (cls == CLS_EQ);
                m.err = (cls == CLS_OTHER);
                m.ns  = (cls == CLS_EQ) ? ST_ACC_EQ : ST_ACC_ASSIGN;
            end
            ST_BANG: begin
                m.err = (cls != CLS_EQ);
                m.ns  = ST_ACC_NE;
            end
            ST_SLASH: begin
                m.adv = (cls == CLS_STAR);
                m.err = (cls == CLS_OTHER);
                m.ns  = (cls == CLS_STAR) ? ST_COMMENT : ST_ACC_DIV;
            end
            ST_COMMENT: begin
                m.ns = (cls == CLS_STAR) ? ST_COMMENT_STAR : ST_COMMENT;
            end
            ST_COMMENT_STAR: begin
                m.ns = (cls == CLS_SLASH) ? ST_ACC_COMMENT : ST_COMMENT;
            end
            default: begin
                // Start state; any code that is never held behaves the same.
                m.err = (cls == CLS_OTHER);
                if (cls == CLS_LETTER) begin
                    m.ns = ST_ID;
                end else if (cls == CLS_DIGIT) begin
                    m.ns = ST_NUM;
                end else if (cls >= CLS_PLUS && cls <= CLS_RBRACE) begin
                    // Single-character tokens map in order onto accepting states.
                    m.ns = cls + (ST_ACC_PLUS - CLS_PLUS);
                end else if (cls == CLS_GT) begin
                    m.ns = ST_GT;
                end else if (cls == CLS_LT) begin
                    m.ns = ST_LT;
                end else if (cls == CLS_EQ) begin
                    m.ns = ST_ASSIGN;
                end else if (cls == CLS_BANG) begin
                    m.ns = ST_BANG;
                end else if (cls == CLS_SLASH) begin
                    m.ns = ST_SLASH;
                end else begin
                    m.ns = ST_START;
                end
            end
        endcase
        return m;
    endfunction

endpackage

### sv/tdts_scan.sv
`timescale 1ns / 1ps

// Scanner state and the per-word step: up to two table passes over one byte,
// producing zero, one or two tokens for the result queue.
module tdts_scan #(
    parameter int LEXEME_MAX = tdts_pkg::LEXEME_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tdts_pkg::t_in_word i_word,
    output tdts_pkg::t_push    o_push
);

    localparam int CNT_W = $clog2(LEXEME_MAX + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LEXEME_MAX);
    localparam logic [CNT_W-1:0] CNT_PREFIX = CNT_W'(tdts_pkg::PREFIX_BYTES);

    // Result of one pass through the transition table.
    typedef struct packed {
        logic             emit;
        logic [4:0]       kind;
        logic             again;
        logic [3:0]       state;
        logic [47:0]      prefix;
        logic [CNT_W-1:0] count;
        logic [15:0]      col;
        logic [CNT_W-1:0] emit_count;
    } t_pass;

    logic [3:0]       r_state;
    logic [47:0]      r_prefix;
    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_line;
    logic [15:0]      r_col;
    logic             r_nl;

    logic [3:0]       n_state;
    logic [47:0]      n_prefix;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      n_line;
    logic [15:0]      n_col;
    logic             n_nl;

    logic                present;
    logic [4:0]          cls;
    logic [15:0]         line_tok;
    logic [15:0]         col_start;
    t_pass               p0;
    t_pass               p1;
    t_pass               fin;
    logic                hold;
    logic [1:0]          num;
    tdts_pkg::t_out_word tok0;
    tdts_pkg::t_out_word tok1;
    tdts_pkg::t_out_word err_tok;
    tdts_pkg::t_out_word end_tok;

    function automatic logic [15:0] sat_inc16(input logic [15:0] x);
        return (x != 16'hFFFF) ? x + 16'd1 : x;
    endfunction

    function automatic logic quiet(input logic [4:0] s);
        return (s == tdts_pkg::ST_COMMENT) || (s == tdts_pkg::ST_COMMENT_STAR);
    endfunction

    // Identifiers are checked against the keywords; other accepts map directly.
    function automatic logic [4:0] accept_kind(input logic [4:0] ns,
                                               input logic [47:0] p,
                                               input logic [CNT_W-1:0] c);
        logic [4:0] k;
        k = ns - (tdts_pkg::ST_ACC_GT - tdts_pkg::KIND_GT);
        if (ns == tdts_pkg::ST_ACC_NUM) begin
            k = tdts_pkg::KIND_NUM;
        end else if (ns == tdts_pkg::ST_ACC_ID) begin
            k = tdts_pkg::KIND_ID;
            for (int i = 0; i < tdts_pkg::KW_COUNT; i++) begin
                if (c == CNT_W'(tdts_pkg::KW_LEN[i]) && p == tdts_pkg::KW_TEXT[i]) begin
                    k = tdts_pkg::KW_KIND[i];
                end
            end
        end
        return k;
    endfunction

    // One pass of the scanner over a byte (or over end of input).
    function automatic t_pass scan_pass(input logic [4:0] st,
                                        input logic [47:0] p,
                                        input logic [CNT_W-1:0] c,
                                        input logic [15:0] col,
                                        input logic [4:0] k,
                                        input logic [7:0] ch,
                                        input logic byte_ok);
        t_pass         r;
        tdts_pkg::t_move m;
        logic          do_append;
        m = tdts_pkg::next_move(st, k);
        r.emit       = 1'b0;
        r.kind       = tdts_pkg::KIND_ERROR;
        r.again      = 1'b0;
        r.state      = st[3:0];
        r.prefix     = p;
        r.count      = c;
        r.col        = col;
        r.emit_count = c;
        do_append = 1'b0;
        if (m.err) begin
            do_append = byte_ok;
        end else if (m.adv && byte_ok) begin
            do_append = (k < tdts_pkg::CLS_SPACE) && !(quiet(st) && quiet(m.ns));
        end
        if (do_append) begin
            if (c < CNT_PREFIX) begin
                r.prefix = p | ({40'd0, ch} << {c[2:0], 3'b000});
            end
            if (c < CNT_MAX) begin
                r.count = c + 1'b1;
            end
        end
        if (byte_ok && (m.err || m.adv)) begin
            r.col = sat_inc16(col);
        end
        if (m.err) begin
            r.emit       = 1'b1;
            r.kind       = tdts_pkg::KIND_ERROR;
            r.emit_count = r.count;
            r.state      = 4'(tdts_pkg::ST_START);
            r.prefix     = 48'd0;
            r.count      = '0;
        end else if (m.ns >= tdts_pkg::ST_ACC_ID) begin
            r.emit       = 1'b1;
            r.kind       = accept_kind(m.ns, r.prefix, r.count);
            r.emit_count = r.count;
            r.again      = !m.adv;
            r.state      = 4'(tdts_pkg::ST_START);
            r.prefix     = 48'd0;
            r.count      = '0;
        end else begin
            r.state = m.ns[3:0];
        end
        return r;
    endfunction

    // Line tracking and both table passes for the word in the input register.
    always_comb begin
        present   = !i_word.end_of_input;
        cls       = present ? tdts_pkg::char_class(i_word.ch) : tdts_pkg::CLS_SPACE;
        line_tok  = (present && r_nl) ? sat_inc16(r_line) : r_line;
        col_start = (present && r_nl) ? 16'd0 : r_col;

        p0 = scan_pass(5'(r_state), r_prefix, r_count, col_start, cls, i_word.ch, present);
        // A non-consuming accept rescans the same byte from the start state.
        p1 = scan_pass(tdts_pkg::ST_START, p0.prefix, p0.count, p0.col, cls,
                       i_word.ch, present);
        fin  = p0.again ? p1 : p0;
        hold = (fin.state != 4'(tdts_pkg::ST_START));

        tok0 = '{token_kind: p0.kind, line_number: line_tok, column: p0.col,
                 lexeme_length: 6'(p0.emit_count), last: 1'b0};
        tok1 = '{token_kind: p1.kind, line_number: line_tok, column: p1.col,
                 lexeme_length: 6'(p1.emit_count), last: 1'b0};
        err_tok = '{token_kind: tdts_pkg::KIND_ERROR, line_number: r_line, column: fin.col,
                    lexeme_length: 6'(fin.count), last: 1'b0};
        end_tok = '{token_kind: tdts_pkg::KIND_END, line_number: r_line, column: fin.col,
                    lexeme_length: 6'd0, last: 1'b0};

        if (present) begin
            num = {1'b0, p0.emit} + {1'b0, p0.again & p1.emit};
            o_push.word0 = tok0;
            o_push.word1 = tok1;
        end else begin
            // At end of input the rescan from start never emits; an unfinished
            // comment leaves a nonzero state and is reported as an error.
            num = (p0.emit || hold) ? 2'd2 : 2'd1;
            o_push.word0 = p0.emit ? tok0 : (hold ? err_tok : end_tok);
            o_push.word1 = end_tok;
        end
        o_push.word0.last = (num == 2'd1);
        o_push.word1.last = 1'b1;
        o_push.num = i_fire ? num : 2'd0;

        // End of input puts the scanner back to its reset values.
        n_state  = r_state;
        n_prefix = r_prefix;
        n_count  = r_count;
        n_line   = r_line;
        n_col    = r_col;
        n_nl     = r_nl;
        if (i_fire) begin
            if (present) begin
                n_state  = fin.state;
                n_prefix = fin.prefix;
                n_count  = fin.count;
                n_line   = line_tok;
                n_col    = fin.col;
                n_nl     = (i_word.ch == tdts_pkg::CH_NEWLINE);
            end else begin
                n_state  = 4'(tdts_pkg::ST_START);
                n_prefix = 48'd0;
                n_count  = '0;
                n_line   = 16'd1;
                n_col    = 16'd0;
                n_nl     = 1'b0;
            end
        end
    end

    // Scanner state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= 4'(tdts_pkg::ST_START);
            r_prefix <= 48'd0;
            r_count  <= '0;
            r_line   <= 16'd1;
            r_col    <= 16'd0;
            r_nl     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prefix <= n_prefix;
            r_count  <= n_count;
            r_line   <= n_line;
            r_col    <= n_col;
            r_nl     <= n_nl;
        end
    end

endmodule

### sv/tdts_out_fifo.sv
`timescale 1ns / 1ps

// Result queue: takes up to two words a cycle, hands out one word a cycle on i_ready.
module tdts_out_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdts_pkg::t_push      i_push,
    output tdts_pkg::t_fifo_stat o_stat,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tdts_pkg::t_out_word  o_word
);

    localparam int DEPTH = tdts_pkg::OUT_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = tdts_pkg::OUT_LVL_W;

    tdts_pkg::t_out_word r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [LVL_W-1:0]    r_level;

    logic [PTR_W-1:0]    n_wr_ptr;
    logic [PTR_W-1:0]    n_rd_ptr;
    logic [LVL_W-1:0]    n_level;
    logic                pop;
    logic [PTR_W-1:0]    wr_ptr_b;

    // Pointer and fill level bookkeeping; pointers wrap since DEPTH is a power of two.
    always_comb begin
        o_valid     = (r_level != '0);
        o_word      = r_mem[r_rd_ptr];
        pop         = o_valid && i_ready;
        wr_ptr_b    = r_wr_ptr + 1'b1;
        n_wr_ptr    = r_wr_ptr + PTR_W'(i_push.num);
        n_rd_ptr    = r_rd_ptr + PTR_W'(pop);
        n_level     = r_level + LVL_W'(i_push.num) - LVL_W'(pop);
        o_stat.room  = (r_level <= LVL_W'(DEPTH - 2));
        o_stat.level = r_level;
    end

    // Word storage.
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.word0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.word1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

endmodule

### sv/table_driven_token_scanner_core.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Word
// input    in         i_in_valid / o_in_ready    i_in_word  (source byte, end mark)
// output   out        o_out_valid / i_out_ready  o_out_word (one token)
//
// One input word can be accepted per cycle while the result queue has room. It is scanned
// straight from the input register; its tokens go into the queue and are offered from there.
// A byte that yields two tokens has them handed out one word at a time. The held word
// waits while the four-word result queue holds three or more words.
// Synchronous active-low reset clears the scanner to the start state, line one,
// column zero; no clearing pass follows it. End of input restores these after its end marker.
`include "table_driven_token_scanner_core_defines.svh"

module table_driven_token_scanner_core #(
    parameter int LEXEME_MAX = tdts_pkg::LEXEME_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tdts_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tdts_pkg::t_out_word o_out_word
);

    logic                 r_in_valid;
    tdts_pkg::t_in_word   r_in_word;
    logic                 n_in_valid;
    logic                 fire;
    tdts_pkg::t_push      push;
    tdts_pkg::t_fifo_stat fifo_stat;
    logic                 eoi_fire;
    logic                 eoi_end_ok;
    logic                 pair_last_ok;
    logic                 in_stall;

    // The held word is scanned once the queue has room for two tokens.
    always_comb begin
        fire       = r_in_valid && fifo_stat.room;
        o_in_ready = !r_in_valid || fire;
        n_in_valid = (i_in_valid && o_in_ready) || (r_in_valid && !fire);
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    tdts_scan #(
        .LEXEME_MAX (LEXEME_MAX)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (r_in_word),
        .o_push  (push)
    );

    tdts_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (fifo_stat),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

    // Conditions watched by the assertions below.
    always_comb begin
        eoi_fire     = fire && r_in_word.end_of_input;
        eoi_end_ok   = (push.num == 2'd1 && push.word0.last
                        && push.word0.token_kind == tdts_pkg::KIND_END)
                       || (push.num == 2'd2 && push.word1.token_kind == tdts_pkg::KIND_END);
        pair_last_ok = !push.word0.last && push.word1.last;
        in_stall     = r_in_valid && !fifo_stat.room;
    end

    // End of input always finishes with the end marker flagged as last.
    `TDTS_ASSERT_NOW(a_eoi_end_marker, eoi_fire, eoi_end_ok, "end of input without end marker")

    // When a byte yields two tokens only the second is flagged last.
    `TDTS_ASSERT_NOW(a_pair_last, push.num == 2'd2, pair_last_ok, "wrong last flags on a pair")

    // The result queue never holds more words than it has entries.
    `TDTS_ASSERT_NOW(a_level_bound, 1'b1, fifo_stat.level <= tdts_pkg::OUT_DEPTH, "overflow")

    // A word stalled for lack of queue room stays in the input register unchanged.
    `TDTS_ASSERT_NEXT(a_stall_hold, in_stall, r_in_valid && $stable(r_in_word), "stalled word lost")

endmodule
